// ----- rtl/pfg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register map and helper functions for the particle force generator.
// No dependencies; every other file in rtl/ imports this package.
package pfg_pkg;

	// Register indexes on the configuration port (byte address = 4 * index).
	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_COEF_A    = 3'd1;
	localparam logic [2:0] REG_COEF_B    = 3'd2;
	localparam logic [2:0] REG_REST      = 3'd3;
	localparam logic [2:0] REG_GRAVITY_X = 3'd4;
	localparam logic [2:0] REG_GRAVITY_Y = 3'd5;
	localparam logic [2:0] REG_GRAVITY_Z = 3'd6;

	// Force laws selected by the mode register.
	localparam logic [2:0] MODE_GRAVITY = 3'd0;
	localparam logic [2:0] MODE_DRAG    = 3'd1;
	localparam logic [2:0] MODE_SPRING  = 3'd2;
	localparam logic [2:0] MODE_ANCHOR  = 3'd3;
	localparam logic [2:0] MODE_BUNGEE  = 3'd4;

	// Square root: 68-bit radicand, one result bit per stage.
	localparam int SQRT_STEPS = 34;
	localparam int RAD_W      = 2 * SQRT_STEPS;
	localparam int ROOT_W     = SQRT_STEPS;

	// Largest force magnitude carried between the scalar and vector stages.
	localparam logic [37:0] MAG_LIM = 38'h3F_FFFF_FFFF;

	// Per-word sideband that travels with the arithmetic through the pipeline.
	typedef struct packed {
		logic [2:0]        mode;
		logic              infinite;
		logic [2:0]        neg;      // sign of each vector component
		logic [2:0][32:0]  mag;      // magnitude of each vector component
		logic [2:0][31:0]  grav;     // finished gravity force
		logic              use_grav;
		logic              use_vec;
		logic              applied;
		logic              m_neg;    // sign of the scalar force
		logic [37:0]       m_mag;    // magnitude of the scalar force
	} pfg_side_t;

	// Saturate a sign and magnitude to a 32-bit two's complement word.
	function automatic logic [31:0] sat32(input logic neg, input logic [63:0] p);
		logic [31:0] r;
		if (!neg) begin
			r = (p > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
		end else begin
			r = (p > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - p[31:0]);
		end
		return r;
	endfunction

	// Clamp a product magnitude to the scalar force limit.
	function automatic logic [37:0] clamp_mag(input logic [63:0] p);
		return (p > {26'd0, MAG_LIM}) ? MAG_LIM : p[37:0];
	endfunction

endpackage

// ----- rtl/pfg_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with sideband passthrough.
// Depends on pfg_pkg.
module pfg_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [pfg_pkg::RAD_W-1:0]  rad,
	input  pfg_pkg::pfg_side_t       in_side,
	output logic                     out_valid,
	output logic [pfg_pkg::ROOT_W-1:0] root,
	output pfg_pkg::pfg_side_t       out_side
);
	import pfg_pkg::*;

	logic [SQRT_STEPS-1:0] vld_s;
	logic [RAD_W-1:0]      rad_s  [SQRT_STEPS];
	logic [37:0]           rem_s  [SQRT_STEPS];
	logic [ROOT_W-1:0]     root_s [SQRT_STEPS];
	pfg_side_t             side_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic              v_in;
		logic [RAD_W-1:0]  rad_in;
		logic [37:0]       rem_in;
		logic [ROOT_W-1:0] root_in;
		pfg_side_t         side_in;
		logic [37:0]       rem_sh;
		logic [37:0]       trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = vld_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		// Bring down the next two radicand bits and try the odd trial value.
		assign rem_sh = {rem_in[35:0], rad_in[2*(SQRT_STEPS-1-k) +: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_in;
				rem_s[k]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS-1];
	assign root      = root_s[SQRT_STEPS-1];
	assign out_side  = side_s[SQRT_STEPS-1];

endmodule

// ----- rtl/pfg_div.sv -----
`timescale 1ns / 1ps
// Pipelined three-lane divider for unit vector components, one quotient bit per stage.
// Depends on pfg_pkg.
module pfg_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [pfg_pkg::ROOT_W-1:0] len,
	input  pfg_pkg::pfg_side_t         in_side,
	output logic                       out_valid,
	output logic [2:0][FRAC_BITS:0]    u,
	output pfg_pkg::pfg_side_t         out_side
);
	import pfg_pkg::*;

	localparam int STEPS = FRAC_BITS + 1;

	logic [STEPS-1:0]      vld_s;
	logic [ROOT_W-1:0]     len_s  [STEPS];
	logic [2:0][34:0]      r_s    [STEPS];
	logic [2:0][FRAC_BITS:0] q_s  [STEPS];
	pfg_side_t             side_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic                    v_in;
		logic [ROOT_W-1:0]       len_in;
		logic [2:0][34:0]        r_in;
		logic [2:0][FRAC_BITS:0] q_in;
		pfg_side_t               side_in;
		logic [2:0][34:0]        r_nxt;
		logic [2:0][FRAC_BITS:0] q_nxt;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign len_in  = len;
			assign side_in = in_side;
			assign q_in    = '0;
			for (genvar j = 0; j < 3; j++) begin : g_lane
				assign r_in[j] = {2'b00, in_side.mag[j]};
			end
		end else begin : g_next
			assign v_in    = vld_s[k-1];
			assign len_in  = len_s[k-1];
			assign side_in = side_s[k-1];
			assign q_in    = q_s[k-1];
			for (genvar j = 0; j < 3; j++) begin : g_lane
				assign r_in[j] = {r_s[k-1][j][33:0], 1'b0};
			end
		end

		// Restoring step on each lane; the remainder stays below the length.
		always_comb begin
			for (int j = 0; j < 3; j++) begin
				if (r_in[j] >= {1'b0, len_in}) begin
					r_nxt[j] = r_in[j] - {1'b0, len_in};
					q_nxt[j] = {q_in[j][FRAC_BITS-1:0], 1'b1};
				end else begin
					r_nxt[j] = r_in[j];
					q_nxt[j] = {q_in[j][FRAC_BITS-1:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[k]  <= len_in;
				r_s[k]    <= r_nxt;
				q_s[k]    <= q_nxt;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign u         = q_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

// ----- rtl/particle_force_generator.sv -----
`timescale 1ns / 1ps
// Top level of the particle force generator: configuration registers and force pipeline.
// Depends on pfg_pkg, pfg_sqrt and pfg_div.
//
// Usage:
// The input channel (in_valid/in_ready) takes one particle word per cycle: position,
// velocity, partner or anchor position, mass and the infinite mass flag. The output
// channel (out_valid/out_ready) returns one force word per particle, in order.
// The mode, coefficients, rest length and gravity are written over the APB port; the
// user must do so only while no particle is in flight, which the block does not enforce.
// A word passes FRAC_BITS + 44 register stages (60 at Q16.16): three input stages,
// 34 square root stages, four scalar stages, FRAC_BITS + 1 divider stages, one
// multiply stage and the output register. out_valid is registered together with the force
// word in the output register; the force words are Q16.16 when FRAC_BITS is 16.
// Throughput is one word per cycle while the receiver does not stall; every stage is
// pipelined, including the square root and the unit vector division.
// When the receiver stalls with a word in the output register, the whole pipeline
// holds; in_ready is low only while that word waits and the pipeline cannot move.
// Reset clears the configuration registers to zero (mode gravity) and empties the pipeline.
module particle_force_generator #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	input  logic [31:0] partner_x,
	input  logic [31:0] partner_y,
	input  logic [31:0] partner_z,
	input  logic [30:0] mass,
	input  logic        infinite_mass,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] force_x,
	output logic [31:0] force_y,
	output logic [31:0] force_z,
	output logic        applied
);
	import pfg_pkg::*;

	// Configuration registers.
	logic [2:0]  mode_q;
	logic [31:0] coef_a_q;
	logic [31:0] coef_b_q;
	logic [30:0] rest_length_q;
	logic [31:0] gravity_x_q;
	logic [31:0] gravity_y_q;
	logic [31:0] gravity_z_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_GRAVITY;
			coef_a_q      <= '0;
			coef_b_q      <= '0;
			rest_length_q <= '0;
			gravity_x_q   <= '0;
			gravity_y_q   <= '0;
			gravity_z_q   <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_MODE:      mode_q        <= pwdata[2:0];
				REG_COEF_A:    coef_a_q      <= pwdata;
				REG_COEF_B:    coef_b_q      <= pwdata;
				REG_REST:      rest_length_q <= pwdata[30:0];
				REG_GRAVITY_X: gravity_x_q   <= pwdata;
				REG_GRAVITY_Y: gravity_y_q   <= pwdata;
				REG_GRAVITY_Z: gravity_z_q   <= pwdata;
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (paddr[4:2])
			REG_MODE:      prdata = {29'd0, mode_q};
			REG_COEF_A:    prdata = coef_a_q;
			REG_COEF_B:    prdata = coef_b_q;
			REG_REST:      prdata = {1'b0, rest_length_q};
			REG_GRAVITY_X: prdata = gravity_x_q;
			REG_GRAVITY_Y: prdata = gravity_y_q;
			REG_GRAVITY_Z: prdata = gravity_z_q;
			default:       prdata = '0;
		endcase
	end

	// The whole pipeline advances unless a finished word is held by the receiver.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic [2:0][31:0] pos_a, vel_a, part_a, grav_a;
	assign pos_a  = {pos_z, pos_y, pos_x};
	assign vel_a  = {vel_z, vel_y, vel_x};
	assign part_a = {partner_z, partner_y, partner_x};
	assign grav_a = {gravity_z_q, gravity_y_q, gravity_x_q};

	logic [31:0] abs_ka, abs_kb;
	logic        ka_neg, kb_neg;
	assign ka_neg = coef_a_q[31];
	assign kb_neg = coef_b_q[31];
	assign abs_ka = ka_neg ? (32'd0 - coef_a_q) : coef_a_q;
	assign abs_kb = kb_neg ? (32'd0 - coef_b_q) : coef_b_q;

	// Stage 1: pick the vector (velocity or separation), take magnitudes, gravity product.
	logic             vld_s1;
	pfg_side_t        side_s1;
	logic [2:0][63:0] gp_s1;
	logic [2:0]       gneg_s1;
	pfg_side_t        side_c1;
	logic [2:0][63:0] gp_c1;

	always_comb begin
		logic [32:0] vec;
		logic [31:0] gabs;
		side_c1          = '0;
		side_c1.mode     = mode_q;
		side_c1.infinite = infinite_mass;
		for (int i = 0; i < 3; i++) begin
			if (mode_q == MODE_DRAG) begin
				vec = {vel_a[i][31], vel_a[i]};
			end else begin
				vec = {pos_a[i][31], pos_a[i]} - {part_a[i][31], part_a[i]};
			end
			side_c1.neg[i] = vec[32];
			side_c1.mag[i] = vec[32] ? (33'd0 - vec) : vec;
			gabs     = grav_a[i][31] ? (32'd0 - grav_a[i]) : grav_a[i];
			gp_c1[i] = 64'(gabs) * 64'(mass);
		end
	end

	// Stage 2: squares of the vector components, gravity saturation.
	logic             vld_s2;
	pfg_side_t        side_s2;
	logic [2:0][65:0] sq_s2;
	pfg_side_t        side_c2;

	always_comb begin
		side_c2 = side_s1;
		for (int i = 0; i < 3; i++) begin
			side_c2.grav[i] = sat32(gneg_s1[i], gp_s1[i] >> FRAC_BITS);
		end
	end

	// Stage 3: sum of squares feeds the square root.
	logic             vld_s3;
	pfg_side_t        side_s3;
	logic [RAD_W-1:0] rad_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c1;
			gp_s1   <= gp_c1;
			for (int i = 0; i < 3; i++) begin
				gneg_s1[i] <= grav_a[i][31];
			end
			side_s2 <= side_c2;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 66'(side_s1.mag[i]) * 66'(side_s1.mag[i]);
			end
			side_s3 <= side_s2;
			rad_s3  <= RAD_W'(sq_s2[0]) + RAD_W'(sq_s2[1]) + RAD_W'(sq_s2[2]);
		end
	end

	logic              sqrt_vld;
	logic [ROOT_W-1:0] sqrt_root;
	pfg_side_t         sqrt_side;

	pfg_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.rad       (rad_s3),
		.in_side   (side_s3),
		.out_valid (sqrt_vld),
		.root      (sqrt_root),
		.out_side  (sqrt_side)
	);

	// Stage 4: scalar argument of the coefficient, law flags, drag speed squared.
	logic              vld_s4;
	pfg_side_t         side_s4;
	logic [ROOT_W-1:0] len_s4;
	logic [63:0]       sq_s4;
	logic [31:0]       xa_s4;
	logic              flip_s4;
	pfg_side_t         side_c4;
	logic [31:0]       xa_c4;
	logic              flip_c4;
	logic [31:0]       sc_c4;

	always_comb begin
		logic signed [35:0] diff;
		logic [35:0]        dabs;
		logic               stretched;
		diff      = signed'({2'b00, sqrt_root}) - signed'({5'd0, rest_length_q});
		dabs      = diff[35] ? (36'd0 - diff) : diff;
		stretched = !diff[35] && (diff != 36'sd0);
		sc_c4     = (sqrt_root[ROOT_W-1:32] != '0) ? 32'hFFFF_FFFF : sqrt_root[31:0];
		side_c4   = sqrt_side;
		side_c4.use_grav = 1'b0;
		side_c4.use_vec  = 1'b0;
		side_c4.applied  = 1'b0;
		xa_c4   = (dabs[35:32] != 4'd0) ? 32'hFFFF_FFFF : dabs[31:0];
		flip_c4 = 1'b1;
		case (sqrt_side.mode)
			MODE_GRAVITY: begin
				side_c4.use_grav = !sqrt_side.infinite;
				side_c4.applied  = !sqrt_side.infinite;
			end
			MODE_DRAG: begin
				xa_c4            = sc_c4;
				side_c4.use_vec  = (sqrt_root != '0);
				side_c4.applied  = 1'b1;
			end
			MODE_SPRING: begin
				side_c4.use_vec  = (sqrt_root != '0);
				side_c4.applied  = 1'b1;
			end
			MODE_ANCHOR: begin
				// Rest minus length is negative when stretched.
				flip_c4          = stretched;
				side_c4.use_vec  = (sqrt_root != '0);
				side_c4.applied  = 1'b1;
			end
			MODE_BUNGEE: begin
				side_c4.use_vec  = stretched;
				side_c4.applied  = stretched;
			end
			default: ;
		endcase
	end

	// Stage 5: linear coefficient product, clamped drag square term.
	logic              vld_s5;
	pfg_side_t         side_s5;
	logic [ROOT_W-1:0] len_s5;
	logic [63:0]       pa_s5;
	logic [31:0]       q_s5;
	logic              flip_s5;
	logic [63:0]       qs_c5;
	assign qs_c5 = sq_s4 >> FRAC_BITS;

	// Stage 6: quadratic coefficient product, clamp of the linear term.
	logic              vld_s6;
	pfg_side_t         side_s6;
	logic [ROOT_W-1:0] len_s6;
	logic [63:0]       pb_s6;
	logic [37:0]       ma_s6;
	logic              flip_s6;

	// Stage 7: final scalar force, sign and magnitude.
	logic              vld_s7;
	pfg_side_t         side_s7;
	logic [ROOT_W-1:0] len_s7;
	logic [37:0]       mb_c7;
	logic signed [39:0] sum_c7;
	logic [39:0]       sabs_c7;
	pfg_side_t         side_c7;

	always_comb begin
		logic signed [39:0] sa;
		logic signed [39:0] sb;
		mb_c7   = clamp_mag(pb_s6 >> FRAC_BITS);
		sa      = signed'({2'b00, ma_s6});
		sb      = signed'({2'b00, mb_c7});
		if (ka_neg) begin
			sa = 40'sd0 - sa;
		end
		if (kb_neg) begin
			sb = 40'sd0 - sb;
		end
		sum_c7  = sa + sb;
		sabs_c7 = sum_c7[39] ? (40'd0 - sum_c7) : sum_c7;
		side_c7 = side_s6;
		if (side_s6.mode == MODE_DRAG) begin
			// Drag opposes the velocity, so the sum is negated.
			side_c7.m_neg = !sum_c7[39];
			side_c7.m_mag = (sabs_c7 > {2'b00, MAG_LIM}) ? MAG_LIM : sabs_c7[37:0];
		end else begin
			side_c7.m_neg = ka_neg ^ flip_s6;
			side_c7.m_mag = ma_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_c4;
			len_s4  <= sqrt_root;
			sq_s4   <= 64'(sc_c4) * 64'(sc_c4);
			xa_s4   <= xa_c4;
			flip_s4 <= flip_c4;

			side_s5 <= side_s4;
			len_s5  <= len_s4;
			pa_s5   <= 64'(abs_ka) * 64'(xa_s4);
			q_s5    <= (qs_c5[63:32] != 32'd0) ? 32'hFFFF_FFFF : qs_c5[31:0];
			flip_s5 <= flip_s4;

			side_s6 <= side_s5;
			len_s6  <= len_s5;
			pb_s6   <= 64'(abs_kb) * 64'(q_s5);
			ma_s6   <= clamp_mag(pa_s5 >> FRAC_BITS);
			flip_s6 <= flip_s5;

			side_s7 <= side_c7;
			len_s7  <= len_s6;
		end
	end

	logic                    div_vld;
	logic [2:0][FRAC_BITS:0] div_u;
	pfg_side_t               div_side;

	pfg_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.len       (len_s7),
		.in_side   (side_s7),
		.out_valid (div_vld),
		.u         (div_u),
		.out_side  (div_side)
	);

	// Stage 8: scalar force times unit vector components.
	logic             vld_s8;
	pfg_side_t        side_s8;
	logic [2:0][63:0] prod_s8;
	logic [2:0]       fneg_s8;

	// Output register: select gravity, vector force or zero, and saturate.
	logic [2:0][31:0] force_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (side_s8.use_grav) begin
				force_c[i] = side_s8.grav[i];
			end else if (side_s8.use_vec) begin
				force_c[i] = sat32(fneg_s8[i], prod_s8[i] >> FRAC_BITS);
			end else begin
				force_c[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= div_side;
			for (int i = 0; i < 3; i++) begin
				prod_s8[i] <= 64'(div_side.m_mag) * 64'(div_u[i]);
				fneg_s8[i] <= div_side.m_neg ^ div_side.neg[i];
			end
			force_x <= force_c[0];
			force_y <= force_c[1];
			force_z <= force_c[2];
			applied <= side_s8.applied;
		end
	end

	// Valid bits of the stages outside the submodules.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= sqrt_vld;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_s8    <= div_vld;
			out_valid <= vld_s8;
		end
	end

	// A skipped force always carries a zero vector.
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !applied |-> force_x == 32'd0 && force_y == 32'd0 && force_z == 32'd0)
		else $error("skipped force word carries a nonzero vector");

	// Undefined modes never apply a force.
	a_no_law: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode_q > MODE_BUNGEE) |-> !applied)
		else $error("force applied under an undefined mode");

	// Words leave only from a pipeline that was filled.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		en && !vld_s8 |=> !out_valid)
		else $error("output valid without a word in the last stage");

endmodule

// ----- tb/pfg_force_checker.sv -----
`timescale 1ns / 1ps
// Force checker for the particle force generator: snoops the APB writes and both word
// channels, predicts each force word and compares it with the block's output. Needs pfg_pkg.
module pfg_force_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	input  logic [31:0] partner_x,
	input  logic [31:0] partner_y,
	input  logic [31:0] partner_z,
	input  logic [30:0] mass,
	input  logic        infinite_mass,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] force_x,
	input  logic [31:0] force_y,
	input  logic [31:0] force_z,
	input  logic        applied,
	output int          errors,
	output int          pending
);
	import pfg_pkg::*;

	localparam int          FRAC   = 16;
	localparam logic [63:0] LIM32  = 64'hFFFF_FFFF;
	localparam logic [63:0] LIM38  = 64'h3F_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fz;
		logic        app;
	} force_word_t;

	// Shadow copy of the configuration registers.
	logic [2:0]  law;
	logic [31:0] ka, kb, gx, gy, gz;
	logic [30:0] rest_len;

	force_word_t force_q[$];

	function automatic longint sx(input logic [31:0] w);
		return longint'(signed'(w));
	endfunction

	function automatic logic [63:0] magn(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [31:0] sat32(input longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Coefficient times scalar with the scalar and product magnitude clamped.
	function automatic longint coef_mul(input longint c, input longint s);
		logic [63:0] x, p;
		x = magn(s);
		if (x > LIM32) x = LIM32;
		p = (magn(c) * x) >> FRAC;
		if (p > LIM38) p = LIM38;
		return ((c < 0) != (s < 0)) ? -longint'(p) : longint'(p);
	endfunction

	// Exact floor square root of the squared length of a vector.
	function automatic logic [63:0] vec_len(input longint a, input longint b, input longint c);
		logic [67:0] acc, rem, root, trial, m;
		acc = 68'(magn(a)) * 68'(magn(a));
		acc += 68'(magn(b)) * 68'(magn(b));
		acc += 68'(magn(c)) * 68'(magn(c));
		rem = 0;
		root = 0;
		for (int i = 33; i >= 0; i--) begin
			rem = (rem << 2) | 68'(acc[2*i +: 2]);
			trial = (root << 2) | 68'd1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 68'd1;
			end else begin
				root = root << 1;
			end
		end
		return root[63:0];
	endfunction

	// Spread a scalar force along the unit vector of d.
	function automatic logic [95:0] along(input longint m, input longint d0, input longint d1,
			input longint d2, input logic [63:0] len);
		longint d [3];
		logic [95:0] r;
		logic [63:0] u, p;
		longint f;
		d[0] = d0; d[1] = d1; d[2] = d2;
		for (int i = 0; i < 3; i++) begin
			f = 0;
			if (len != 0) begin
				u = (magn(d[i]) << FRAC) / len;
				p = (magn(m) * u) >> FRAC;
				f = ((m < 0) != (d[i] < 0)) ? -longint'(p) : longint'(p);
			end
			r[95 - 32*i -: 32] = sat32(f);
		end
		return r;
	endfunction

	// Gravity component: g times mass, both fixed point.
	function automatic longint coef_mul_grav(input longint g);
		logic [63:0] p;
		p = (magn(g) * {33'd0, mass}) >> FRAC;
		return (g < 0) ? -longint'(p) : longint'(p);
	endfunction

	function automatic force_word_t predict_force();
		force_word_t r;
		longint d0, d1, d2, v0, v1, v2, m, delta, rl;
		logic [63:0] len, s, sc, q;
		r = '0;
		d0 = sx(pos_x) - sx(partner_x);
		d1 = sx(pos_y) - sx(partner_y);
		d2 = sx(pos_z) - sx(partner_z);
		v0 = sx(vel_x); v1 = sx(vel_y); v2 = sx(vel_z);
		rl = longint'({33'd0, rest_len});
		case (law)
			MODE_GRAVITY: begin
				if (!infinite_mass) begin
					r.fx = sat32(coef_mul_grav(sx(gx)));
					r.fy = sat32(coef_mul_grav(sx(gy)));
					r.fz = sat32(coef_mul_grav(sx(gz)));
					r.app = 1'b1;
				end
			end
			MODE_DRAG: begin
				s = vec_len(v0, v1, v2);
				sc = (s > LIM32) ? LIM32 : s;
				q = (sc * sc) >> FRAC;
				if (q > LIM32) q = LIM32;
				m = coef_mul(sx(ka), longint'(s)) + coef_mul(sx(kb), longint'(q));
				if (m > longint'(LIM38)) m = longint'(LIM38);
				if (m < -longint'(LIM38)) m = -longint'(LIM38);
				{r.fx, r.fy, r.fz} = along(-m, v0, v1, v2, s);
				r.app = 1'b1;
			end
			MODE_SPRING: begin
				len = vec_len(d0, d1, d2);
				delta = longint'(len) - rl;
				if (delta < 0) delta = -delta;
				{r.fx, r.fy, r.fz} = along(-coef_mul(sx(ka), delta), d0, d1, d2, len);
				r.app = 1'b1;
			end
			MODE_ANCHOR: begin
				len = vec_len(d0, d1, d2);
				{r.fx, r.fy, r.fz} = along(coef_mul(sx(ka), rl - longint'(len)), d0, d1, d2, len);
				r.app = 1'b1;
			end
			MODE_BUNGEE: begin
				len = vec_len(d0, d1, d2);
				if (longint'(len) > rl) begin
					{r.fx, r.fy, r.fz} = along(-coef_mul(sx(ka), longint'(len) - rl),
						d0, d1, d2, len);
					r.app = 1'b1;
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// Track configuration, queue predictions and compare output words.
	always @(posedge clk or negedge arst_n) begin
		force_word_t want, got;
		if (!arst_n) begin
			law <= MODE_GRAVITY;
			ka <= '0; kb <= '0; gx <= '0; gy <= '0; gz <= '0;
			rest_len <= '0;
			errors <= 0;
			pending <= 0;
			force_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_MODE:      law <= pwdata[2:0];
					REG_COEF_A:    ka <= pwdata;
					REG_COEF_B:    kb <= pwdata;
					REG_REST:      rest_len <= pwdata[30:0];
					REG_GRAVITY_X: gx <= pwdata;
					REG_GRAVITY_Y: gy <= pwdata;
					REG_GRAVITY_Z: gz <= pwdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				force_q = {force_q, predict_force()};
			if (out_valid && out_ready) begin
				got = '{force_x, force_y, force_z, applied};
				if (force_q.size() == 0) begin
					if (errors < 10)
						$display("force word with none expected: %h %h %h applied %b",
							force_x, force_y, force_z, applied);
					errors <= errors + 1;
				end else begin
					want = force_q.pop_front();
					if (want !== got) begin
						if (errors < 10)
							$display("force mismatch: expected %h %h %h applied %b, got %h %h %h applied %b",
								want.fx, want.fy, want.fz, want.app,
								got.fx, got.fy, got.fz, got.app);
						errors <= errors + 1;
					end
				end
			end
			pending <= force_q.size();
		end
	end

endmodule

// ----- tb/tb_particle_force_generator.sv -----
`timescale 1ns / 1ps
// Testbench top for the particle force generator: clock, reset, APB setup and particle stimulus.
// Depends on pfg_pkg, the RTL and pfg_force_checker.
module tb_particle_force_generator;
	import pfg_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
	logic [31:0] partner_x, partner_y, partner_z;
	logic [30:0] mass;
	logic        infinite_mass;
	logic [31:0] force_x, force_y, force_z;
	logic        applied;
	int          errors, pending;
	int          ready_pct;
	int          cycles;
	int          burst_left;

	particle_force_generator u_top (.*);

	pfg_force_checker u_chk (.*);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver stalls at a rate that changes from phase to phase.
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) < ready_pct);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("tb_particle_force_generator: FAIL");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_law(input logic [2:0] law, input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] rest, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		reg_write(REG_MODE, {29'd0, law});
		reg_write(REG_COEF_A, a);
		reg_write(REG_COEF_B, b);
		reg_write(REG_REST, rest);
		reg_write(REG_GRAVITY_X, x);
		reg_write(REG_GRAVITY_Y, y);
		reg_write(REG_GRAVITY_Z, z);
	endtask

	// Let the pipeline drain completely before touching the registers.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	// Present one particle word and hold it until accepted; bursts and gaps come first.
	task automatic send_word(input logic [31:0] px, py, pz, vx, vy, vz, qx, qy, qz,
			input logic [30:0] m, input logic inf);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_valid <= 1'b1;
		pos_x <= px; pos_y <= py; pos_z <= pz;
		vel_x <= vx; vel_y <= vy; vel_z <= vz;
		partner_x <= qx; partner_y <= qy; partner_z <= qz;
		mass <= m;
		infinite_mass <= inf;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_word();
		logic [31:0] v;
		case ($urandom_range(0, 6))
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			2: v = $urandom_range(0, 32'h40000);
			3: v = -$urandom_range(0, 32'h40000);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] near(input logic [31:0] p);
		return p + $urandom_range(0, 32'h80000) - 32'h40000;
	endfunction

	// Random particle; the partner is usually close so springs see realistic lengths.
	task automatic send_random();
		logic [31:0] px, py, pz;
		px = rnd_word(); py = rnd_word(); pz = rnd_word();
		if ($urandom_range(0, 3) != 0)
			send_word(px, py, pz, rnd_word(), rnd_word(), rnd_word(),
				near(px), near(py), near(pz), 31'(rnd_word()), $urandom_range(0, 5) == 0);
		else
			send_word(px, py, pz, rnd_word(), rnd_word(), rnd_word(),
				rnd_word(), rnd_word(), rnd_word(), 31'(rnd_word()),
				$urandom_range(0, 5) == 0);
	endtask

	initial begin
		logic [2:0] law;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; out_ready = 1'b0; infinite_mass = 1'b0; mass = '0;
		pos_x = '0; pos_y = '0; pos_z = '0; vel_x = '0; vel_y = '0; vel_z = '0;
		partner_x = '0; partner_y = '0; partner_z = '0;
		ready_pct = 100;
		cycles = 0;
		burst_left = 8;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset configuration, then gravity extremes and infinite mass.
		send_word('0, '0, '0, '0, '0, '0, '0, '0, '0, 31'h7FFF_FFFF, 1'b0);
		drain();
		set_law(MODE_GRAVITY, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFF6_0000);
		send_word('0, '0, '0, '0, '0, '0, '0, '0, '0, 31'h7FFF_FFFF, 1'b0);
		send_word('0, '0, '0, '0, '0, '0, '0, '0, '0, 31'h0001_0000, 1'b1);
		send_word('0, '0, '0, '0, '0, '0, '0, '0, '0, 31'd0, 1'b0);
		drain();
		// Drag: zero velocity, extreme velocity and an ordinary velocity.
		set_law(MODE_DRAG, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0);
		send_word('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
		send_word('0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			'0, '0, '0, '0, 1'b0);
		send_word('0, '0, '0, 32'h0003_0000, 32'hFFFC_0000, '0, '0, '0, '0, '0, 1'b0);
		drain();
		// Springs: zero length, huge distance, stretched and slack bungee.
		for (int k = 0; k < 3; k++) begin
			law = (k == 0) ? MODE_SPRING : (k == 1) ? MODE_ANCHOR : MODE_BUNGEE;
			set_law(law, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000, '0, '0, '0);
			send_word(32'h0001_0000, '0, '0, '0, '0, '0, 32'h0001_0000, '0, '0, '0, 1'b0);
			send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0,
				32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, 1'b0);
			send_word(32'h0005_0000, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
			send_word(32'h0000_8000, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
			drain();
		end
		// Unused mode values give no force.
		set_law(3'd7, '0, '0, '0, '0, '0, '0);
		send_word(32'h0001_0000, '0, '0, '0, '0, '0, '0, '0, '0, 31'h10000, 1'b0);
		drain();
		set_law(3'd5, '0, '0, '0, '0, '0, '0);
		send_word(32'h0001_0000, '0, '0, '0, '0, '0, '0, '0, '0, 31'h10000, 1'b0);
		drain();

		// Random phases across all laws and register settings.
		for (int ph = 0; ph < 12; ph++) begin
			ready_pct = (ph % 4 == 0) ? 100 : $urandom_range(20, 95);
			set_law(3'(ph % 5), rnd_word(), rnd_word(), rnd_word() & 32'h7FFF_FFFF,
				rnd_word(), rnd_word(), rnd_word());
			for (int n = 0; n < 50; n++) begin
				if (n == 25 && ph == 5) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				send_random();
			end
			drain();
		end

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("tb_particle_force_generator: PASS");
		else
			$display("tb_particle_force_generator: FAIL");
		$finish;
	end

endmodule
